[sv/window_sender_dupack_control_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the window sender
// Shared forms for the concurrent checks of the window sender modules.
// ----------------------------------------------------------------------------
`ifndef WINDOW_SENDER_DUPACK_CONTROL_TOP_ASSERT_SVH
`define WINDOW_SENDER_DUPACK_CONTROL_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WSDC_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsdc check failed");

// Next-cycle implication, checked out of reset.
`define WSDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsdc check failed");

`endif

[sv/wsdc_pkg.sv]
// ----------------------------------------------------------------------------
// Window sender package
// Widths, codes and shared types of the window sender block.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdc_pkg;

    // Payload bytes per data segment; must be a power of two.
    localparam int SEG_PAYLOAD = 1024;
    localparam int SEG_SHIFT   = $clog2(SEG_PAYLOAD);

    localparam int FILE_W  = 24;
    localparam int DUP_W   = 8;
    localparam int SEG_W   = 15;
    localparam int WIN_W   = 16;
    localparam int LEN_W   = 11;
    localparam int REQ_W   = 2;
    localparam int EV_W    = 4;
    localparam int TOTAL_W = FILE_W - SEG_SHIFT + 1;
    localparam int CMP_W   = (TOTAL_W > SEG_W) ? TOTAL_W : SEG_W;

    localparam int IN_DATA_W  = ((SEG_W + 7) / 8) * 8;
    localparam int OUT_BITS   = SEG_W + FILE_W + LEN_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes.
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_FILE_LENGTH = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_DUP_LIMIT   = 1'b1;

    localparam logic [DUP_W-1:0] DUP_LIMIT_RST = 8'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEND  = 2'd0,
        REQ_ACK   = 2'd1,
        REQ_START = 2'd2
    } t_req;

    typedef enum logic [EV_W-1:0] {
        EV_DATA    = 4'd0,
        EV_SIZE    = 4'd1,
        EV_FIN     = 4'd2,
        EV_NOSEND  = 4'd3,
        EV_ACKOK   = 4'd4,
        EV_DUP     = 4'd5,
        EV_IGNORED = 4'd6,
        EV_BEYOND  = 4'd7,
        EV_RETX    = 4'd8,
        EV_STARTED = 4'd9
    } t_event;

    typedef struct packed {
        logic [FILE_W-1:0]  file_length;
        logic [DUP_W-1:0]   dup_limit;
        logic [TOTAL_W-1:0] seg_total;
    } t_cfg;

    typedef struct packed {
        t_event             event_res;
        logic [SEG_W-1:0]   seg_num;
        logic               last_flag;
        logic [FILE_W-1:0]  payload_offset;
        logic [LEN_W-1:0]   payload_len;
        logic               transfer_done;
    } t_result;

endpackage

`default_nettype wire

[sv/wsdc_cfg.sv]
// ----------------------------------------------------------------------------
// Window sender configuration registers
// Holds file length and duplicate limit and keeps the segment total ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdc_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [wsdc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [wsdc_pkg::FILE_W-1:0] i_cfg_wdata,
    output wsdc_pkg::t_cfg                  o_cfg
);
    import wsdc_pkg::*;

    logic [FILE_W-1:0]  r_file_length;
    logic [DUP_W-1:0]   r_dup_limit;
    logic [TOTAL_W-1:0] r_seg_total;

    // The total is length / SEG_PAYLOAD + 1, precomputed at write time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
            r_dup_limit   <= DUP_LIMIT_RST;
            r_seg_total   <= TOTAL_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FILE_LENGTH: begin
                    r_file_length <= i_cfg_wdata;
                    r_seg_total   <= TOTAL_W'(i_cfg_wdata >> SEG_SHIFT) + TOTAL_W'(1);
                end
                CFG_DUP_LIMIT: begin
                    r_dup_limit <= i_cfg_wdata[DUP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.file_length = r_file_length;
    assign o_cfg.dup_limit   = r_dup_limit;
    assign o_cfg.seg_total   = r_seg_total;

endmodule

`default_nettype wire

[sv/wsdc_core.sv]
// ----------------------------------------------------------------------------
// Window sender core
// Window, in-flight and duplicate state with the per-request result logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "window_sender_dupack_control_top_assert.svh"

module wsdc_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire wsdc_pkg::t_req            i_req,
    input  wire logic [wsdc_pkg::SEG_W-1:0] i_ack,
    input  wire wsdc_pkg::t_cfg            i_cfg,
    output wsdc_pkg::t_result              o_result
);
    import wsdc_pkg::*;

    localparam logic [SEG_W-1:0] SEG_MAX = {SEG_W{1'b1}};
    localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};
    localparam logic [DUP_W-1:0] DUP_MAX = {DUP_W{1'b1}};

    logic [SEG_W-1:0] r_next_seg, n_next_seg;
    logic [WIN_W-1:0] r_window, n_window;
    logic [WIN_W-1:0] r_in_flight, n_in_flight;
    logic [SEG_W-1:0] r_last_acked, n_last_acked;
    logic [DUP_W-1:0] r_dup_seen, n_dup_seen;
    logic             r_all_acked, n_all_acked;
    logic             r_fin_done, n_fin_done;
    t_result          res;

    function automatic logic [SEG_W-1:0] sat_inc(input logic [SEG_W-1:0] v);
        sat_inc = (v == SEG_MAX) ? v : v + 1'b1;
    endfunction

    always_comb begin : proc_next
        logic [CMP_W-1:0]  v_next;
        logic [CMP_W-1:0]  v_total;
        logic [CMP_W-1:0]  v_ack;
        logic [FILE_W-1:0] v_off;
        logic [DUP_W-1:0]  v_dup;

        n_next_seg   = r_next_seg;
        n_window     = r_window;
        n_in_flight  = r_in_flight;
        n_last_acked = r_last_acked;
        n_dup_seen   = r_dup_seen;
        n_all_acked  = r_all_acked;
        n_fin_done   = r_fin_done;
        res           = '0;
        res.event_res = EV_IGNORED;
        v_next  = CMP_W'(r_next_seg);
        v_total = CMP_W'(i_cfg.seg_total);
        v_ack   = CMP_W'(i_ack);
        v_off   = FILE_W'(r_next_seg - 1'b1) << SEG_SHIFT;
        v_dup   = r_dup_seen;

        case (i_req)
            REQ_START: begin
                n_next_seg    = '0;
                n_window      = WIN_W'(1);
                n_in_flight   = '0;
                n_last_acked  = '0;
                n_dup_seen    = '0;
                n_all_acked   = 1'b0;
                n_fin_done    = 1'b0;
                res.event_res = EV_STARTED;
            end
            REQ_SEND: begin
                if (r_all_acked && v_next > v_total) begin
                    if (!r_fin_done) begin
                        n_fin_done    = 1'b1;
                        res.event_res = EV_FIN;
                    end else begin
                        res.event_res = EV_NOSEND;
                    end
                end else if (v_next <= v_total && r_in_flight < r_window) begin
                    res.seg_num = r_next_seg;
                    if (r_next_seg == '0) begin
                        res.event_res = EV_SIZE;
                    end else begin
                        res.event_res      = EV_DATA;
                        res.payload_offset = v_off;
                        if (v_next == v_total) begin
                            res.last_flag   = 1'b1;
                            res.payload_len = LEN_W'(i_cfg.file_length - v_off);
                        end else begin
                            res.payload_len = LEN_W'(SEG_PAYLOAD);
                        end
                    end
                    if (r_in_flight != WIN_MAX) begin
                        n_in_flight = r_in_flight + 1'b1;
                    end
                    n_next_seg = sat_inc(r_next_seg);
                end else begin
                    res.event_res = EV_NOSEND;
                end
            end
            REQ_ACK: begin
                if (!r_all_acked) begin
                    if (i_ack == r_last_acked && r_dup_seen >= i_cfg.dup_limit) begin
                        res.event_res = EV_IGNORED;
                    end else begin
                        if (r_in_flight != '0) begin
                            n_in_flight = r_in_flight - 1'b1;
                        end
                        if (v_ack <= v_next) begin
                            if (i_ack == r_last_acked) begin
                                if (r_dup_seen != DUP_MAX) begin
                                    v_dup = r_dup_seen + 1'b1;
                                end
                                res.event_res = EV_DUP;
                            end else begin
                                v_dup         = '0;
                                res.event_res = EV_ACKOK;
                            end
                            n_last_acked = i_ack;
                            if (r_window != WIN_MAX) begin
                                n_window = r_window + 1'b1;
                            end
                        end else begin
                            n_next_seg    = sat_inc(i_ack);
                            res.event_res = EV_BEYOND;
                        end
                        n_dup_seen = v_dup;
                        // Duplicate threshold reached: rewind to the first
                        // unacknowledged segment with the window shrunk to one segment.
                        if (v_dup == i_cfg.dup_limit) begin
                            n_next_seg    = sat_inc(n_last_acked);
                            n_window      = WIN_W'(1);
                            n_in_flight   = '0;
                            res.event_res = EV_RETX;
                        end
                    end
                    if (v_ack == v_total) begin
                        n_all_acked = 1'b1;
                    end
                end
            end
            default: begin
                res.event_res = EV_IGNORED;
            end
        endcase

        res.transfer_done = n_all_acked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seg   <= '0;
            r_window     <= WIN_W'(1);
            r_in_flight  <= '0;
            r_last_acked <= '0;
            r_dup_seen   <= '0;
            r_all_acked  <= 1'b0;
            r_fin_done   <= 1'b0;
        end else if (i_valid) begin
            r_next_seg   <= n_next_seg;
            r_window     <= n_window;
            r_in_flight  <= n_in_flight;
            r_last_acked <= n_last_acked;
            r_dup_seen   <= n_dup_seen;
            r_all_acked  <= n_all_acked;
            r_fin_done   <= n_fin_done;
        end
    end

    assign o_result = res;

    `WSDC_ASSERT(a_fin_after_ack, i_clk, i_rst_n, r_fin_done, r_all_acked)
    `WSDC_ASSERT(a_ack_ignored_when_done, i_clk, i_rst_n, i_valid && r_all_acked && i_req == REQ_ACK, res.event_res == EV_IGNORED)
    `WSDC_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, i_valid && i_req == REQ_START, r_next_seg == '0 && r_in_flight == '0 && !r_all_acked && !r_fin_done)
    `WSDC_ASSERT_NEXT(a_retx_closes_window, i_clk, i_rst_n, i_valid && res.event_res == EV_RETX, r_window == WIN_W'(1) && r_in_flight == '0)
    `WSDC_ASSERT_NEXT(a_send_counts, i_clk, i_rst_n, i_valid && (res.event_res == EV_DATA || res.event_res == EV_SIZE), r_in_flight != '0)

endmodule

`default_nettype wire

[sv/window_sender_dupack_control_top.sv]
// Path: a request goes through the input register, then the result register.
// Throughput: one request per cycle while the result stream is not stalled;
// the state update of the core is a single pass of compares and increments,
// so requests follow back to back.
// Reset: synchronous, active low; resets the window state, empties both
// registers, and sets file_length to 0 and dup_limit to 3.
// ----------------------------------------------------------------------------
// Window sender with duplicate-ACK fast retransmit
// Stream-side wrapper: input register, window core and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module window_sender_dupack_control_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write port.
    input  wire logic                           i_cfg_we,
    input  wire logic [wsdc_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [wsdc_pkg::FILE_W-1:0]    i_cfg_wdata,
    // Request stream.
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: ack_num [14:0], zero padding above.
    input  wire logic [wsdc_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // tuser: req_type [1:0].
    input  wire logic [wsdc_pkg::REQ_W-1:0]     i_s_axis_tuser,
    // Result stream.
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata: seg_num [14:0], payload_offset [38:15], payload_len [49:39],
    // transfer_done [50], zero padding above.
    output logic [wsdc_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // tuser: event_res [3:0].
    output logic [wsdc_pkg::EV_W-1:0]           o_m_axis_tuser,
    // tlast: last_flag, set on the final data segment of the file.
    output logic                                o_m_axis_tlast
);
    import wsdc_pkg::*;

    t_cfg             cfg;
    t_result          core_res;
    logic             advance;

    logic             r_in_valid;
    t_req             r_in_req;
    logic [SEG_W-1:0] r_in_ack;
    logic             r_out_valid;
    t_result          r_out;

    // The user must write configuration only while no request is in progress; the block itself does not enforce it.
    wsdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // A held request moves into the core as soon as the result register is
    // empty or is being drained in the same cycle. The input register takes a
    // new request whenever it is empty or its contents move on, so a waiting
    // result blocks new requests only once the input register is full too.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_req <= t_req'(i_s_axis_tuser);
            r_in_ack <= i_s_axis_tdata[SEG_W-1:0];
        end
    end

    wsdc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_req    (r_in_req),
        .i_ack    (r_in_ack),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    // Result register: every request yields exactly one result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.event_res;
    assign o_m_axis_tlast  = r_out.last_flag;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}},
                              r_out.transfer_done,
                              r_out.payload_len,
                              r_out.payload_offset,
                              r_out.seg_num};

endmodule

`default_nettype wire
